/* rtl/pmap_pkg.sv */
// Shared types and constants for the page home node and offset mapper.
// Used by the controller, the datapath and the top level.
package pmap_pkg;

  localparam int PAGE_BITS = 12;
  localparam int CFG_W     = 41;
  localparam int NODE_W    = 7;
  localparam int PPB_W     = 11;
  localparam int POL_W     = 3;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_NODES  = 2'd1;
  localparam logic [1:0] REG_BYTES  = 2'd2;
  localparam logic [1:0] REG_PPB    = 2'd3;

  localparam logic [POL_W-1:0] POL_NAIVE       = 3'd0;
  localparam logic [POL_W-1:0] POL_PRIME_BLOCK = 3'd6;

  localparam logic [1:0] KIND_CYCLIC = 2'd0;
  localparam logic [1:0] KIND_SKEW   = 2'd1;
  localparam logic [1:0] KIND_PRIME  = 2'd2;

  typedef enum logic [3:0] {
    ST_NAIVE, ST_UNIT, ST_HOMEN, ST_SKEW, ST_PRIME,
    ST_FOLD, ST_WALK, ST_OSPLIT, ST_STOPN, ST_STOPP
  } step_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_PREP, S_GO, S_RUN, S_CAP, S_FIN, S_OUT, S_DONE
  } state_t;

  typedef struct packed {
    logic  load;
    logic  prep;
    logic  div_start;
    logic  capture;
    logic  fin;
    logic  out;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic       cfg_err;
    logic       naive;
    logic [1:0] kind;
    logic       div_done;
    logic       m_ge_n;
    logic       walk_go;
  } sts_t;

endpackage

/* rtl/pmap_div.sv */
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the mapper datapath.
module pmap_div #(
  parameter int DW = 41,
  parameter int VW = 41
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [DW-1:0] sh;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {remainder, sh[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(DW);
      end else if (running) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh        <= dividend;
      dvs       <= divisor;
      remainder <= '0;
      quotient  <= '0;
    end else if (running) begin
      sh        <= {sh[DW-2:0], 1'b0};
      quotient  <= {quotient[DW-2:0], fits};
      remainder <= fits ? VW'(trial - {1'b0, dvs}) : trial[VW-1:0];
    end
  end

endmodule

/* rtl/pmap_dp.sv */
// Datapath of the mapper: configuration registers, item registers, shared
// multiplier and divider. Depends on pmap_pkg and pmap_div.
module pmap_dp #(
  parameter int ADDR_BITS = 40,
  parameter int MAX_NODES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [1:0]                   wr_index,
  input  logic [pmap_pkg::CFG_W-1:0]   wr_data,
  input  logic [39:0]                  global_offset,
  input  pmap_pkg::cmd_t               cmd,
  output pmap_pkg::sts_t               sts,
  output logic [5:0]                   home_node,
  output logic [39:0]                  node_offset,
  output logic                         range_error
);
  import pmap_pkg::*;

  localparam int DW  = ADDR_BITS + 1;
  localparam int OW  = ADDR_BITS + 2;
  localparam int PGW = OW - PAGE_BITS;
  localparam int MW  = DW + PPB_W;

  logic [POL_W-1:0]  policy;
  logic [NODE_W-1:0] node_count;
  logic [CFG_W-1:0]  bytes_per_node;
  logic [PPB_W-1:0]  pages_per_block;

  logic [ADDR_BITS-1:0] a_reg;
  logic                 err_cfg;
  logic [DW-1:0] b0, bq, c0, lim, tq, oq, stop, sq, sp;
  logic [PPB_W-1:0]  wpg;
  logic [NODE_W-1:0] home, m, om;
  logic              hq_hi;
  logic [OW-1:0]     off_reg;

  logic [DW-1:0]     dvd;
  logic [CFG_W-1:0]  dvs;
  logic              div_done;
  logic [DW-1:0]     q;
  logic [CFG_W-1:0]  r;

  logic [NODE_W-1:0] n, p, e;
  logic [7:0]        n3;
  logic              blocked, walk_mode, pa_nz, err;
  logic [1:0]        kind;
  logic [PPB_W-1:0]  ubp;
  logic [DW-1:0]     lp, mul_x, fin_x, o_val, s_val;
  logic [PPB_W-1:0]  mul_y;
  logic [MW-1:0]     prod;
  logic [PGW-1:0]    pages;
  logic [47:0]       g48;
  logic [63:0]       off64;

  assign n       = node_count;
  assign n3      = 8'(n) * 8'd3;
  assign p       = n3[7:1];
  assign e       = p - n;
  assign blocked = ~policy[0];
  assign kind    = 2'((policy - 3'd1) >> 1);
  assign ubp     = blocked ? pages_per_block : PPB_W'(1);
  assign g48     = {8'b0, global_offset};
  assign pa_nz   = |a_reg[ADDR_BITS-1:PAGE_BITS];
  assign lp      = DW'(a_reg[ADDR_BITS-1:PAGE_BITS]) - DW'(pa_nz);
  assign walk_mode = (kind == KIND_PRIME) && (m < n);

  assign sts.cfg_err  = (n == '0) || (32'(n) > MAX_NODES) || (policy > POL_PRIME_BLOCK) ||
                        ((policy == POL_NAIVE) && (bytes_per_node == '0)) ||
                        ((policy != POL_NAIVE) && blocked && (pages_per_block == '0));
  assign sts.naive    = policy == POL_NAIVE;
  assign sts.kind     = kind;
  assign sts.div_done = div_done;
  assign sts.m_ge_n   = m >= n;
  assign sts.walk_go  = (e != '0) && (lim > DW'(home));

  always_comb begin
    fin_x = walk_mode ? (sq + c0 - sp) : bq;
    mul_x = fin_x;
    mul_y = ubp;
    if (cmd.prep) begin
      case (cmd.step)
        ST_FOLD:   begin mul_x = c0; mul_y = PPB_W'(e); end
        ST_OSPLIT: begin mul_x = tq; mul_y = PPB_W'(n); end
        ST_STOPN:  begin mul_x = oq; mul_y = PPB_W'(p); end
        default:   begin mul_x = fin_x; mul_y = ubp; end
      endcase
    end
  end

  assign prod  = MW'(mul_x) * MW'(mul_y);
  assign o_val = DW'(home) + DW'(prod);
  assign s_val = sts.walk_go ? DW'(prod) + DW'(n) + DW'(om) : DW'(home);
  assign pages = PGW'(prod) + PGW'(wpg) + PGW'(pa_nz && (home == '0));

  assign off64 = 64'(off_reg);
  assign err   = err_cfg || hq_hi || (home >= n) || (off64 >= 64'(bytes_per_node));

  always_ff @(posedge clk) begin
    if (rst) begin
      policy          <= POL_NAIVE;
      node_count      <= NODE_W'(1);
      bytes_per_node  <= CFG_W'(64'd1 << 30);
      pages_per_block <= PPB_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_POLICY: policy          <= wr_data[POL_W-1:0];
        REG_NODES:  node_count      <= wr_data[NODE_W-1:0];
        REG_BYTES:  bytes_per_node  <= wr_data;
        REG_PPB:    pages_per_block <= wr_data[PPB_W-1:0];
        default:    policy          <= policy;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg   <= g48[ADDR_BITS-1:0];
      err_cfg <= sts.cfg_err;
      hq_hi   <= 1'b0;
      home    <= '0;
      m       <= '0;
    end
    if (cmd.prep) begin
      case (cmd.step)
        ST_NAIVE:  begin dvd <= DW'(a_reg); dvs <= bytes_per_node; end
        ST_UNIT:   begin dvd <= lp; dvs <= CFG_W'(ubp); end
        ST_HOMEN:  begin dvd <= b0; dvs <= CFG_W'(n); end
        ST_SKEW:   begin dvd <= b0 + bq; dvs <= CFG_W'(n); end
        ST_PRIME:  begin dvd <= b0; dvs <= CFG_W'(p); end
        ST_FOLD: begin
          lim <= DW'(prod);
          dvd <= DW'(prod) + DW'(m) - DW'(n);
          dvs <= CFG_W'(n);
        end
        ST_WALK:   begin dvd <= lim - DW'(1) - DW'(home); dvs <= CFG_W'(n); end
        ST_OSPLIT: begin dvd <= o_val; dvs <= CFG_W'(e); end
        ST_STOPN:  begin stop <= s_val; dvd <= s_val; dvs <= CFG_W'(n); end
        ST_STOPP:  begin dvd <= stop; dvs <= CFG_W'(p); end
        default:   begin dvd <= dvd; dvs <= dvs; end
      endcase
    end
    if (cmd.capture) begin
      case (cmd.step)
        ST_NAIVE: begin
          home    <= q[NODE_W-1:0];
          hq_hi   <= |q[DW-1:NODE_W];
          off_reg <= OW'(r);
        end
        ST_UNIT:   begin b0 <= q; wpg <= r[PPB_W-1:0]; end
        ST_HOMEN:  begin bq <= q; home <= r[NODE_W-1:0]; end
        ST_SKEW:   home <= r[NODE_W-1:0];
        ST_PRIME:  begin c0 <= q; m <= r[NODE_W-1:0]; home <= r[NODE_W-1:0]; end
        ST_FOLD: begin
          if (m >= n) begin
            home <= r[NODE_W-1:0];
          end
        end
        ST_WALK:   tq <= q;
        ST_OSPLIT: begin oq <= q; om <= r[NODE_W-1:0]; end
        ST_STOPN:  sq <= q;
        ST_STOPP:  sp <= q;
        default:   sp <= sp;
      endcase
    end
    if (cmd.fin) begin
      off_reg <= {pages, a_reg[PAGE_BITS-1:0]};
    end
    if (cmd.out) begin
      home_node   <= err ? 6'd0 : home[5:0];
      node_offset <= err ? 40'd0 : off64[39:0];
      range_error <= err;
    end
  end

  pmap_div #(.DW(DW), .VW(CFG_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (q),
    .remainder (r)
  );

endmodule

/* rtl/pmap_ctrl.sv */
// Controller of the mapper: sequences the division steps of one item.
// Depends on pmap_pkg.
module pmap_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  pmap_pkg::sts_t sts,
  output pmap_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);
  import pmap_pkg::*;

  state_t state, state_next;
  step_t  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= ST_NAIVE;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd           = '0;
    cmd.step      = step;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.cfg_err) begin
          state_next = S_OUT;
        end else begin
          step_next  = sts.naive ? ST_NAIVE : ST_UNIT;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_GO;
      end
      S_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_RUN;
      end
      S_RUN: begin
        if (sts.div_done) begin
          cmd.capture = 1'b1;
          state_next  = S_CAP;
        end
      end
      S_CAP: begin
        state_next = S_PREP;
        unique case (step)
          ST_NAIVE: state_next = S_OUT;
          ST_UNIT:  step_next = ST_HOMEN;
          ST_HOMEN: begin
            if (sts.kind == KIND_SKEW) begin
              step_next = ST_SKEW;
            end else if (sts.kind == KIND_PRIME) begin
              step_next = ST_PRIME;
            end else begin
              state_next = S_FIN;
            end
          end
          ST_PRIME:  step_next = ST_FOLD;
          ST_FOLD: begin
            if (sts.m_ge_n) begin
              state_next = S_FIN;
            end else begin
              step_next = sts.walk_go ? ST_WALK : ST_STOPN;
            end
          end
          ST_WALK:   step_next = ST_OSPLIT;
          ST_OSPLIT: step_next = ST_STOPN;
          ST_STOPN:  step_next = ST_STOPP;
          default:   state_next = S_FIN;
        endcase
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

endmodule

/* rtl/page_home_node_and_offset_mapper_top.sv */
// Top level of the page home node and offset mapper.
// Depends on pmap_pkg, pmap_ctrl and pmap_dp.
//
//   channel  | handshake         | payload
//   config   | wr_en             | wr_index, wr_data
//   request  | start, busy       | global_offset
//   result   | done              | home_node, node_offset, range_error
//
// An item needs one division under the naive policy and up to eight under the others,
// all on the single shared divider of ADDR_BITS + 1 steps; a configuration error
// skips them. A new request is taken only in idle, after done of the last item.
// Reset is synchronous and loads the register defaults; no clearing pass.
// The result beat is shown for one cycle on done and cannot be stalled.
module page_home_node_and_offset_mapper_top #(
  parameter int ADDR_BITS = 40,
  parameter int MAX_NODES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [1:0]                  wr_index,
  input  logic [pmap_pkg::CFG_W-1:0]  wr_data,
  input  logic                        start,
  output logic                        busy,
  input  logic [39:0]                 global_offset,
  output logic                        done,
  output logic [5:0]                  home_node,
  output logic [39:0]                 node_offset,
  output logic                        range_error
);
  import pmap_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pmap_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pmap_dp #(.ADDR_BITS(ADDR_BITS), .MAX_NODES(MAX_NODES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .global_offset (global_offset),
    .cmd           (cmd),
    .sts           (sts),
    .home_node     (home_node),
    .node_offset   (node_offset),
    .range_error   (range_error)
  );

endmodule
